// ----- src/sbot_pkg.sv -----
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared widths, command codes and control structs for the segment/box
// occlusion test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbot_pkg;

  localparam int COORD_BITS = 20;
  localparam int SIZE_BITS  = 16;

  localparam int WIDE_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  // doubled-unit box bounds and doubled centres
  localparam int BND_BITS  = WIDE_BITS + 2;
  // differences of bounds (direction, corner offsets, overlap extents)
  localparam int DIF_BITS  = BND_BITS + 1;
  localparam int PROD_BITS = 2 * DIF_BITS;
  localparam int SGN_BITS  = PROD_BITS + 1;
  // positive overlap extent, at most twice a size
  localparam int EXT_BITS  = SIZE_BITS + 1;
  localparam int OV_BITS   = 2 * EXT_BITS;
  localparam int AREA_BITS = 2 * SIZE_BITS;

  // stream packing
  localparam int IN_FIELD_BITS  = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS  = 3;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_TEST        = 2'd2;
  localparam logic [1:0] CMD_FINISH      = 2'd3;

  typedef struct packed {
    logic       load_end;    // capture endpoint box from the input word
    logic       end_sel;     // 0 first endpoint, 1 second
    logic       load_cand;   // capture candidate box from the input word
    logic       ext_en;      // range check, overlap extents, sign flags init
    logic       mul_corner;  // corner cross products
    logic       acc_en;      // fold previous corner sign into flags
    logic [1:0] corner;
    logic       ovl_en;      // overlap area product
    logic       ovl_sel;
    logic       decide;      // settle verdict
    logic       out_load;    // latch result bit
  } dp_cmd_t;

  typedef struct packed {
    logic settled;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/segment_box_occlusion_test.sv -----
// ----------------------------------------------------------------------------
// segment_box_occlusion_test
// Decides whether the segment joining two loaded endpoint box centres passes
// through a streamed candidate box, and reports the first crossing's verdict.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Width | Contents
// --------+-----+-------+----------------------------------------------------
// s_*     | in  | 72+3  | tdata: box word, tuser: command, is_endpoint
// m_*     | out | 8     | tdata: skips_over
//
// Sequence: load and finish words are taken in the idle state. A test word runs
// through capture, five corner steps, two overlap steps and decide; the two
// corner multipliers are reused over the four box corners and the area
// multiplier over the two endpoints. A skipped test is taken and starts no steps.
// Reset: endpoints become zero-size boxes at the origin, verdict cleared.
// Stalls: the result sits in an output register; only a finish word waits
// while an earlier result has not been taken.
//
`timescale 1ns / 1ps
`default_nettype none

module segment_box_occlusion_test import sbot_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // centre_x [19:0], centre_z [39:20], box_width [55:40], box_height [71:56]
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  // command [1:0], is_endpoint [2]
  input  wire logic [IN_TUSER_BITS-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // skips_over [0]
  output logic [OUT_TDATA_BITS-1:0]      m_tdata
);

  logic signed [COORD_BITS-1:0] centre_x, centre_z;
  logic        [SIZE_BITS-1:0]  box_width, box_height;
  logic        [1:0]            command;
  logic                         is_endpoint;
  logic                         skips_over;
  dp_cmd_t                      cmd;
  dp_status_t                   status;

  // unpack the input word
  assign centre_x    = s_tdata[COORD_BITS-1:0];
  assign centre_z    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign box_width   = s_tdata[2*COORD_BITS+SIZE_BITS-1:2*COORD_BITS];
  assign box_height  = s_tdata[2*COORD_BITS+2*SIZE_BITS-1:2*COORD_BITS+SIZE_BITS];
  assign command     = s_tuser[1:0];
  assign is_endpoint = s_tuser[2];

  sbot_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .command     (command),
    .is_endpoint (is_endpoint),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .status      (status),
    .cmd         (cmd)
  );

  sbot_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .centre_x   (centre_x),
    .centre_z   (centre_z),
    .box_width  (box_width),
    .box_height (box_height),
    .status     (status),
    .skips_over (skips_over)
  );

  // result bit in the lowest position, rest zero
  assign m_tdata = OUT_TDATA_BITS'(skips_over);

endmodule

`default_nettype wire

// ----- src/sbot_controller.sv -----
// ----------------------------------------------------------------------------
// sbot_controller
// Sequencer: accepts words, steps the datapath through corner and overlap
// phases of a test, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbot_controller import sbot_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [1:0] command,
  input  wire logic       is_endpoint,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CORNER = 2'd1;
  localparam logic [1:0] ST_OVL    = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       accept;

  // a finish must wait for the previous result to leave
  assign s_tready = (state == ST_IDLE) &&
                    !(m_tvalid && !m_tready && command == CMD_FINISH);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_LOAD_FIRST: begin
              cmd.load_end = 1'b1;
              cmd.end_sel  = 1'b0;
            end
            CMD_LOAD_SECOND: begin
              cmd.load_end = 1'b1;
              cmd.end_sel  = 1'b1;
            end
            CMD_TEST: begin
              if (!(status.settled || is_endpoint)) begin
                cmd.load_cand = 1'b1;
                state_next    = ST_CORNER;
                cnt_next      = '0;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_CORNER: begin
        cmd.ext_en     = (cnt == 3'd0);
        cmd.mul_corner = (cnt < 3'd4);
        cmd.acc_en     = (cnt != 3'd0);
        cmd.corner     = cnt[1:0];
        if (cnt == 3'd4) begin
          state_next = ST_OVL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_OVL: begin
        cmd.ovl_en  = 1'b1;
        cmd.ovl_sel = cnt[0];
        if (cnt[0]) begin
          state_next = ST_DECIDE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/sbot_datapath.sv -----
// ----------------------------------------------------------------------------
// sbot_datapath
// Endpoint and candidate registers, two corner multipliers, one area
// multiplier, slab/side tests and the verdict registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbot_datapath import sbot_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dp_cmd_t                      cmd,
  input  wire logic signed [COORD_BITS-1:0] centre_x,
  input  wire logic signed [COORD_BITS-1:0] centre_z,
  input  wire logic        [SIZE_BITS-1:0]  box_width,
  input  wire logic        [SIZE_BITS-1:0]  box_height,
  output dp_status_t                        status,
  output logic                              skips_over
);

  // endpoint boxes, doubled units
  logic signed [BND_BITS-1:0]  e_px [2];
  logic signed [BND_BITS-1:0]  e_pz [2];
  logic signed [BND_BITS-1:0]  e_x0 [2];
  logic signed [BND_BITS-1:0]  e_x1 [2];
  logic signed [BND_BITS-1:0]  e_z0 [2];
  logic signed [BND_BITS-1:0]  e_z1 [2];
  logic        [AREA_BITS-1:0] e_area [2];

  // candidate box
  logic signed [BND_BITS-1:0]  c_x0, c_x1, c_z0, c_z1;
  logic        [AREA_BITS-1:0] c_area;

  logic                        meet;
  logic                        all_pos, all_neg;
  logic signed [PROD_BITS-1:0] prod_a, prod_b;
  logic        [EXT_BITS-1:0]  ov_w [2];
  logic        [EXT_BITS-1:0]  ov_h [2];
  logic                        ov_pos [2];
  logic        [OV_BITS-1:0]   ov_area [2];
  logic                        settled, value;

  // input word in doubled units
  logic signed [BND_BITS-1:0]  in_x2, in_z2, in_w, in_h;
  assign in_x2 = BND_BITS'(centre_x) <<< 1;
  assign in_z2 = BND_BITS'(centre_z) <<< 1;
  assign in_w  = signed'({{(BND_BITS - SIZE_BITS){1'b0}}, box_width});
  assign in_h  = signed'({{(BND_BITS - SIZE_BITS){1'b0}}, box_height});

  // area multiplier: box area on capture, overlap area in the overlap phase
  logic [EXT_BITS-1:0] ma_x, ma_y;
  logic [OV_BITS-1:0]  ma_out;
  always_comb begin
    if (cmd.ovl_en) begin
      ma_x = ov_w[cmd.ovl_sel];
      ma_y = ov_h[cmd.ovl_sel];
    end else begin
      ma_x = EXT_BITS'(box_width);
      ma_y = EXT_BITS'(box_height);
    end
  end
  assign ma_out = OV_BITS'(ma_x) * OV_BITS'(ma_y);

  // corner side test: dz*(cx-px) against dx*(cz-pz)
  logic signed [DIF_BITS-1:0]  dx, dz, off_x, off_z;
  logic signed [BND_BITS-1:0]  cx, cz;
  logic signed [SGN_BITS-1:0]  side;
  assign dx    = DIF_BITS'(e_px[1]) - DIF_BITS'(e_px[0]);
  assign dz    = DIF_BITS'(e_pz[1]) - DIF_BITS'(e_pz[0]);
  assign cx    = cmd.corner[0] ? c_x1 : c_x0;
  assign cz    = cmd.corner[1] ? c_z1 : c_z0;
  assign off_x = DIF_BITS'(cx) - DIF_BITS'(e_px[0]);
  assign off_z = DIF_BITS'(cz) - DIF_BITS'(e_pz[0]);
  assign side  = SGN_BITS'(prod_a) - SGN_BITS'(prod_b);

  // slab range check on segment's bounding box
  logic signed [BND_BITS-1:0] seg_xlo, seg_xhi, seg_zlo, seg_zhi;
  assign seg_xlo = (e_px[0] < e_px[1]) ? e_px[0] : e_px[1];
  assign seg_xhi = (e_px[0] < e_px[1]) ? e_px[1] : e_px[0];
  assign seg_zlo = (e_pz[0] < e_pz[1]) ? e_pz[0] : e_pz[1];
  assign seg_zhi = (e_pz[0] < e_pz[1]) ? e_pz[1] : e_pz[0];

  // overlap rectangle against each endpoint
  logic signed [DIF_BITS-1:0] ext_w [2];
  logic signed [DIF_BITS-1:0] ext_h [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [BND_BITS-1:0] l, r, b, t;
      l = (c_x0 > e_x0[k]) ? c_x0 : e_x0[k];
      r = (c_x1 < e_x1[k]) ? c_x1 : e_x1[k];
      b = (c_z0 > e_z0[k]) ? c_z0 : e_z0[k];
      t = (c_z1 < e_z1[k]) ? c_z1 : e_z1[k];
      ext_w[k] = DIF_BITS'(r) - DIF_BITS'(l);
      ext_h[k] = DIF_BITS'(t) - DIF_BITS'(b);
    end
  end

  // heavy overlap: 2*ov > 4*area  <=>  ov > 2*area
  logic heavy [2];
  logic crossed;
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      heavy[k] = ov_pos[k] &&
                 ((ov_area[k] > OV_BITS'({e_area[k], 1'b0})) ||
                  (ov_area[k] > OV_BITS'({c_area, 1'b0})));
    end
  end
  assign crossed = meet && !all_pos && !all_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2; k++) begin
        e_px[k]   <= '0;
        e_pz[k]   <= '0;
        e_x0[k]   <= '0;
        e_x1[k]   <= '0;
        e_z0[k]   <= '0;
        e_z1[k]   <= '0;
        e_area[k] <= '0;
      end
      settled <= 1'b0;
      value   <= 1'b0;
    end else begin
      if (cmd.load_end) begin
        if (cmd.end_sel) begin
          e_px[1]   <= in_x2;
          e_pz[1]   <= in_z2;
          e_x0[1]   <= in_x2 - in_w;
          e_x1[1]   <= in_x2 + in_w;
          e_z0[1]   <= in_z2 - in_h;
          e_z1[1]   <= in_z2 + in_h;
          e_area[1] <= ma_out[AREA_BITS-1:0];
        end else begin
          e_px[0]   <= in_x2;
          e_pz[0]   <= in_z2;
          e_x0[0]   <= in_x2 - in_w;
          e_x1[0]   <= in_x2 + in_w;
          e_z0[0]   <= in_z2 - in_h;
          e_z1[0]   <= in_z2 + in_h;
          e_area[0] <= ma_out[AREA_BITS-1:0];
        end
        settled <= 1'b0;
        value   <= 1'b0;
      end
      if (cmd.decide && crossed) begin
        settled <= 1'b1;
        value   <= !(heavy[0] || heavy[1]);
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_cand) begin
      c_x0   <= in_x2 - in_w;
      c_x1   <= in_x2 + in_w;
      c_z0   <= in_z2 - in_h;
      c_z1   <= in_z2 + in_h;
      c_area <= ma_out[AREA_BITS-1:0];
    end
    if (cmd.ext_en) begin
      meet <= (seg_xlo <= c_x1) && (seg_xhi >= c_x0) &&
              (seg_zlo <= c_z1) && (seg_zhi >= c_z0);
      for (int k = 0; k < 2; k++) begin
        ov_w[k]   <= ext_w[k][EXT_BITS-1:0];
        ov_h[k]   <= ext_h[k][EXT_BITS-1:0];
        ov_pos[k] <= (ext_w[k] > 0) && (ext_h[k] > 0);
      end
    end
    if (cmd.mul_corner) begin
      prod_a <= PROD_BITS'(dz) * PROD_BITS'(off_x);
      prod_b <= PROD_BITS'(dx) * PROD_BITS'(off_z);
    end
    if (cmd.ext_en) begin
      all_pos <= 1'b1;
      all_neg <= 1'b1;
    end else if (cmd.acc_en) begin
      all_pos <= all_pos && (side > 0);
      all_neg <= all_neg && (side < 0);
    end
    if (cmd.ovl_en) begin
      if (cmd.ovl_sel) begin
        ov_area[1] <= ma_out;
      end else begin
        ov_area[0] <= ma_out;
      end
    end
    if (cmd.out_load) begin
      skips_over <= settled && value;
    end
  end

  assign status.settled = settled;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - segment_box_occlusion_test
// Drives command words (endpoint loads, box tests, finishes) into the slave
// stream. A scoreboard predicts each finish verdict with exact integer
// geometry and checks it against every word taken from the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import sbot_pkg::*;

// Verdict predictor and result store
class occlusion_checker;
  longint first_x, first_z, first_w, first_h;
  longint second_x, second_z, second_w, second_h;
  bit     settled, value;
  bit     due_verdicts[$];
  int     mismatches;
  int     live_words;   // words taken by the block

  function new();
    first_x = 0; first_z = 0; first_w = 0; first_h = 0;
    second_x = 0; second_z = 0; second_w = 0; second_h = 0;
    settled = 0; value = 0; mismatches = 0; live_words = 0;
  endfunction

  function bit span_meets(longint p, longint q, longint lo, longint hi);
    longint a, b;
    a = (p < q) ? p : q;
    b = (p < q) ? q : p;
    return (a <= hi) && (b >= lo);
  endfunction

  // inclusive slab test on doubled units
  function bit segment_hits(longint x0, longint x1, longint z0, longint z1);
    longint px, pz, qx, qz, dx, dz, cx, cz, s;
    int pos, neg;
    px = 2 * first_x;  pz = 2 * first_z;
    qx = 2 * second_x; qz = 2 * second_z;
    dx = qx - px; dz = qz - pz;
    pos = 0; neg = 0;
    if (!span_meets(px, qx, x0, x1) || !span_meets(pz, qz, z0, z1)) return 0;
    for (int i = 0; i < 4; i++) begin
      cx = i[0] ? x1 : x0;
      cz = i[1] ? z1 : z0;
      s  = dz * (cx - px) - dx * (cz - pz);
      if (s > 0) pos++;
      else if (s < 0) neg++;
    end
    return !(pos == 4 || neg == 4);
  endfunction

  // overlap beyond half of either box's area
  function bit heavy_overlap(longint x0, longint x1, longint z0, longint z1,
                             longint ex, longint ez, longint ew, longint eh,
                             longint cw, longint ch);
    longint l, r, b, t, ov2;
    l = (x0 > 2 * ex - ew) ? x0 : 2 * ex - ew;
    r = (x1 < 2 * ex + ew) ? x1 : 2 * ex + ew;
    b = (z0 > 2 * ez - eh) ? z0 : 2 * ez - eh;
    t = (z1 < 2 * ez + eh) ? z1 : 2 * ez + eh;
    if (!(l < r && b < t)) return 0;
    ov2 = 2 * (r - l) * (t - b);
    return (ov2 > 4 * ew * eh) || (ov2 > 4 * cw * ch);
  endfunction

  function void note(logic [1:0] cmd, logic [COORD_BITS-1:0] xf,
                     logic [COORD_BITS-1:0] zf, logic [SIZE_BITS-1:0] wf,
                     logic [SIZE_BITS-1:0] hf, logic skip);
    longint x, z, w, h, x0, x1, z0, z1;
    x = longint'(signed'(xf));
    z = longint'(signed'(zf));
    w = longint'(wf);
    h = longint'(hf);
    live_words++;
    case (cmd)
      CMD_LOAD_FIRST: begin
        first_x = x; first_z = z; first_w = w; first_h = h;
        settled = 0; value = 0;
      end
      CMD_LOAD_SECOND: begin
        second_x = x; second_z = z; second_w = w; second_h = h;
        settled = 0; value = 0;
      end
      CMD_TEST: begin
        if (settled || skip) return;
        x0 = 2 * x - w; x1 = 2 * x + w;
        z0 = 2 * z - h; z1 = 2 * z + h;
        if (!segment_hits(x0, x1, z0, z1)) return;
        settled = 1;
        value = !(heavy_overlap(x0, x1, z0, z1, first_x, first_z, first_w, first_h,
                                w, h) ||
                  heavy_overlap(x0, x1, z0, z1, second_x, second_z, second_w,
                                second_h, w, h));
      end
      default: begin
        due_verdicts = {due_verdicts, bit'(settled && value)};
      end
    endcase
  endfunction

  function void check(logic got);
    bit want;
    if (due_verdicts.size() == 0) begin
      $error("skips_over: no verdict due, actual %0d", got);
      mismatches++;
      return;
    end
    want = due_verdicts.pop_front();
    if (got !== want) begin
      $error("skips_over: expected %0d, actual %0d", want, got);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam int Z_LSB        = COORD_BITS;
  localparam int W_LSB        = 2 * COORD_BITS;
  localparam int H_LSB        = 2 * COORD_BITS + SIZE_BITS;
  localparam int WORD_TARGET  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 500000;

  logic                      clk = 0;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  // centre_x, centre_z, box_width, box_height (lowest first)
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  // command, is_endpoint (lowest first)
  logic [IN_TUSER_BITS-1:0]  s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // skips_over
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  occlusion_checker chk = new();
  int  cycles = 0;
  int  burst_left = 0;
  bit  calm = 0;       // sender runs without gaps while set

  segment_box_occlusion_test dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Both streams sampled at the rising edge, before the block's own updates
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        chk.note(s_tuser[1:0], s_tdata[0 +: COORD_BITS], s_tdata[Z_LSB +: COORD_BITS],
                 s_tdata[W_LSB +: SIZE_BITS], s_tdata[H_LSB +: SIZE_BITS], s_tuser[2]);
      if (m_tvalid && m_tready)
        chk.check(m_tdata[0]);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: modes of steady ready, coin-flip, sparse pulses and long stalls
  initial begin
    int mode, left;
    m_tready = 0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: m_tready = 1;
        1: m_tready = $urandom_range(0, 1);
        2: m_tready = (left % 6) == 0;
        default: m_tready = ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  function automatic int near(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, (1 << COORD_BITS) - 1)) - (1 << (COORD_BITS - 1));
  endfunction

  // One word on the slave stream; called at a falling edge, returns at one.
  // Bursts of back-to-back words, random gaps between bursts.
  task automatic put_word(logic [1:0] cmd, int x, int z, int w, int h, bit skip);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!calm) begin
        s_tvalid = 0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata = '0;
    s_tdata[0 +: COORD_BITS]     = x[COORD_BITS-1:0];
    s_tdata[Z_LSB +: COORD_BITS] = z[COORD_BITS-1:0];
    s_tdata[W_LSB +: SIZE_BITS]  = w[SIZE_BITS-1:0];
    s_tdata[H_LSB +: SIZE_BITS]  = h[SIZE_BITS-1:0];
    s_tuser  = {skip, cmd};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Load two endpoints, test a few boxes, finish. Boxes mostly sit along the
  // segment so that crossings, misses and heavy overlaps all turn up.
  task automatic run_session();
    int ax, az, bx, bz, aw, ah, bw, bh;
    int spread, lim, base_x, base_z, n, t, cx, cz;
    case ($urandom_range(0, 3))
      0: spread = 64;
      1: spread = 2000;
      2: spread = 60000;
      default: spread = 300000;
    endcase
    lim    = (spread < 65535) ? spread : 65535;
    base_x = int'($urandom_range(0, 400000)) - 200000;
    base_z = int'($urandom_range(0, 400000)) - 200000;
    ax = near(base_x, spread);
    az = near(base_z, spread);
    aw = $urandom_range(0, lim);
    ah = $urandom_range(0, lim);
    bw = $urandom_range(0, lim);
    bh = $urandom_range(0, lim);
    case ($urandom_range(0, 7))
      0: begin bx = ax; bz = az; end                 // point segment
      1: begin bx = ax; bz = near(base_z, spread); end
      2: begin bx = near(base_x, spread); bz = az; end
      default: begin bx = near(base_x, spread); bz = near(base_z, spread); end
    endcase
    if ($urandom_range(0, 1)) begin
      put_word(CMD_LOAD_FIRST, ax, az, aw, ah, $urandom_range(0, 1));
      put_word(CMD_LOAD_SECOND, bx, bz, bw, bh, $urandom_range(0, 1));
    end else begin
      put_word(CMD_LOAD_SECOND, bx, bz, bw, bh, $urandom_range(0, 1));
      put_word(CMD_LOAD_FIRST, ax, az, aw, ah, $urandom_range(0, 1));
    end
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: put_word(CMD_TEST, ax, az, aw, ah, $urandom_range(0, 3) != 0);
        1: put_word(CMD_TEST, bx, bz, bw, bh, $urandom_range(0, 3) != 0);
        2: put_word(CMD_TEST, near(base_x, spread), near(base_z, spread),
                    $urandom_range(0, lim), $urandom_range(0, lim), 0);
        default: begin
          t  = $urandom_range(0, 16);
          cx = ax + (bx - ax) * t / 16 + near(0, spread / 32);
          cz = az + (bz - az) * t / 16 + near(0, spread / 32);
          put_word(CMD_TEST, cx, cz, $urandom_range(0, lim / 2),
                   $urandom_range(0, lim / 2), $urandom_range(0, 7) == 0);
        end
      endcase
    end
    put_word(CMD_FINISH, any_coord(), any_coord(), 0, 0, 0);
    if ($urandom_range(0, 3) == 0) begin
      // late test after the verdict may already be settled, then finish again
      put_word(CMD_TEST, near(ax, spread), near(az, spread), lim, lim, 0);
      put_word(CMD_FINISH, 0, 0, $urandom_range(0, 65535), 0, $urandom_range(0, 1));
    end
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n)
      put_word(2'($urandom_range(0, 3)), any_coord(), any_coord(),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  initial begin
    rst      = 1;
    s_tvalid = 0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Before any load both ends are zero-size boxes at the origin
    put_word(CMD_TEST, 0, 0, 4, 4, 0);
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);

    // Corner-to-corner diagonal at the coordinate extremes
    put_word(CMD_LOAD_FIRST, -524288, 524287, 65535, 0, 0);
    put_word(CMD_LOAD_SECOND, 524287, -524288, 0, 65535, 0);
    put_word(CMD_TEST, 0, 0, 65535, 65535, 1);    // endpoint flag: skipped
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);          // nothing crossed yet
    put_word(CMD_TEST, 0, 0, 65535, 65535, 0);
    put_word(CMD_TEST, 0, 0, 0, 0, 0);            // already settled
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);

    // Horizontal segment; box edge touching the line counts as a crossing
    put_word(CMD_LOAD_FIRST, 0, 0, 100, 100, 0);
    put_word(CMD_LOAD_SECOND, 1000, 0, 100, 100, 0);
    put_word(CMD_TEST, 500, 300, 0, 100, 0);
    put_word(CMD_TEST, 500, 50, 0, 100, 0);
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);

    // Vertical segment; box mostly on top of the first end
    put_word(CMD_LOAD_FIRST, 0, 0, 100, 100, 0);
    put_word(CMD_LOAD_SECOND, 0, 1000, 100, 100, 0);
    put_word(CMD_TEST, 10, 10, 100, 100, 0);
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);

    // Point segment: only boxes holding the point cross it
    put_word(CMD_LOAD_SECOND, 0, 0, 40, 40, 0);
    put_word(CMD_TEST, 30, 30, 20, 20, 0);
    put_word(CMD_TEST, -524288, 524287, 65535, 65535, 0);
    put_word(CMD_TEST, 5, -5, 20, 20, 0);
    put_word(CMD_FINISH, 0, 0, 0, 0, 0);

    while (chk.live_words < WORD_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) run_noise();
      else run_session();
    end
    s_tvalid = 0;

    while (chk.due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
